// ===== rtl/icmp4_header_parser_defines.svh =====
// Assertion helpers for the ICMPv4 parser; clk and rst_n are taken from the
// enclosing module.
`ifndef ICMP4_HEADER_PARSER_DEFINES_SVH
`define ICMP4_HEADER_PARSER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ICMP4_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ICMP4_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/icmp4_pkg.sv =====
package icmp4_pkg;

  localparam int HDR_KEEP  = 20;
  localparam int HDR_IDX_W = $clog2(HDR_KEEP);
  localparam int CNT_W     = 16;

  localparam logic [CNT_W-1:0] MAX_MESSAGE_BYTES = 16'd65535;
  localparam logic [CNT_W-1:0] MIN_BASE_BYTES    = 16'd4;
  localparam logic [CNT_W-1:0] MIN_HDR_BYTES     = 16'd8;
  localparam logic [CNT_W-1:0] TS_MSG_BYTES      = 16'd20;

  // RFC 792 type numbers
  localparam logic [7:0] TYPE_ECHO_REPLY    = 8'd0;
  localparam logic [7:0] TYPE_DEST_UNREACH  = 8'd3;
  localparam logic [7:0] TYPE_SRC_QUENCH    = 8'd4;
  localparam logic [7:0] TYPE_REDIRECT      = 8'd5;
  localparam logic [7:0] TYPE_ECHO_REQUEST  = 8'd8;
  localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;
  localparam logic [7:0] TYPE_PARAM_PROBLEM = 8'd12;
  localparam logic [7:0] TYPE_TS_REQUEST    = 8'd13;
  localparam logic [7:0] TYPE_TS_REPLY      = 8'd14;
  localparam logic [7:0] TYPE_INFO_REQUEST  = 8'd15;
  localparam logic [7:0] TYPE_INFO_REPLY    = 8'd16;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_MISSING = 2'd1;
  localparam logic [1:0] STATUS_TS_LONG = 2'd2;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd3;

  typedef logic [HDR_KEEP-1:0][7:0] hdr_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  msg_type;
    logic [7:0]  msg_code;
    logic [15:0] checksum;
    logic [15:0] ident;
    logic [15:0] seq_number;
    logic [31:0] rest_word;
    logic [31:0] orig_ts;
    logic [31:0] recv_ts;
    logic [31:0] xmit_ts;
    logic [15:0] payload_length;
    logic [15:0] total_length;
  } result_t;

endpackage

// ===== rtl/icmp4_decode.sv =====
module icmp4_decode
  import icmp4_pkg::*;
(
  input  hdr_t             hdr,
  input  logic [CNT_W-1:0] total,
  output result_t          res
);

  logic ok;

  always_comb begin
    res = '0;
    ok  = 1'b0;
    if (total < MIN_BASE_BYTES) begin
      res.status = STATUS_MISSING;
    end else begin
      case (hdr[0]) inside
        TYPE_ECHO_REPLY, TYPE_ECHO_REQUEST, TYPE_INFO_REQUEST, TYPE_INFO_REPLY: begin
          if (total < MIN_HDR_BYTES) begin
            res.status = STATUS_MISSING;
          end else begin
            ok                 = 1'b1;
            res.ident          = {hdr[4], hdr[5]};
            res.seq_number     = {hdr[6], hdr[7]};
            res.payload_length = total - MIN_HDR_BYTES;
          end
        end
        TYPE_DEST_UNREACH, TYPE_SRC_QUENCH, TYPE_REDIRECT, TYPE_TIME_EXCEEDED,
        TYPE_PARAM_PROBLEM: begin
          if (total < MIN_HDR_BYTES) begin
            res.status = STATUS_MISSING;
          end else begin
            ok                 = 1'b1;
            res.rest_word      = {hdr[4], hdr[5], hdr[6], hdr[7]};
            res.payload_length = total - MIN_HDR_BYTES;
          end
        end
        TYPE_TS_REQUEST, TYPE_TS_REPLY: begin
          if (total < TS_MSG_BYTES) begin
            res.status = STATUS_MISSING;
          end else if (total > TS_MSG_BYTES) begin
            res.status = STATUS_TS_LONG;
          end else begin
            ok             = 1'b1;
            res.ident      = {hdr[4], hdr[5]};
            res.seq_number = {hdr[6], hdr[7]};
            res.orig_ts    = {hdr[8], hdr[9], hdr[10], hdr[11]};
            res.recv_ts    = {hdr[12], hdr[13], hdr[14], hdr[15]};
            res.xmit_ts    = {hdr[16], hdr[17], hdr[18], hdr[19]};
          end
        end
        default: begin
          res.status = STATUS_UNKNOWN;
        end
      endcase
    end

    if (ok) begin
      res.status       = STATUS_OK;
      res.msg_type     = hdr[0];
      res.msg_code     = hdr[1];
      res.checksum     = {hdr[2], hdr[3]};
      res.total_length = total;
    end
  end

endmodule

// ===== rtl/icmp4_header_parser.sv =====
// out_valid rises once the last byte has passed the input register and then the
// result register.
// Throughput: one byte per cycle; a message gives its result on its last byte.
// Only a last byte meeting an undelivered, stalled result is held back.
// Reset (synchronous, rst_n low) clears the byte count and both valid flags;
// the 20-byte header store has no reset and is only read where written.
module icmp4_header_parser
  import icmp4_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [7:0]  out_msg_type,
  output logic [7:0]  out_msg_code,
  output logic [15:0] out_checksum,
  output logic [15:0] out_ident,
  output logic [15:0] out_seq_number,
  output logic [31:0] out_rest_word,
  output logic [31:0] out_orig_ts,
  output logic [31:0] out_recv_ts,
  output logic [31:0] out_xmit_ts,
  output logic [15:0] out_payload_length,
  output logic [15:0] out_total_length
);

`include "icmp4_header_parser_defines.svh"

  logic             in_valid_r;
  logic [7:0]       byte_r;
  logic             last_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [CNT_W-1:0] total_nxt;
  hdr_t             hdr_r;
  hdr_t             hdr_view;
  result_t          res_nxt;
  result_t          res_r;
  logic             out_valid_r;
  logic             blocked;
  logic             fire;
  logic             fire_last;
  logic             err_out;
  logic             err_nonzero;
  logic             ts_out;
  logic             ts_len_ok;

  // a last byte can only move on when the result register is free
  assign blocked   = in_valid_r && last_r && out_valid_r && out_stall;
  assign fire      = in_valid_r && !blocked;
  assign fire_last = fire && last_r;
  assign in_stall  = blocked;

  assign total_nxt = (count_r == MAX_MESSAGE_BYTES) ? count_r : count_r + 16'd1;
  assign count_nxt = fire ? (last_r ? '0 : total_nxt) : count_r;

  // bypass the byte being stored so the decode sees the whole header
  always_comb begin
    hdr_view = hdr_r;
    for (int i = 0; i < HDR_KEEP; i++) begin
      if (count_r == CNT_W'(i)) begin
        hdr_view[i] = byte_r;
      end
    end
  end

  icmp4_decode u_decode (
    .hdr   (hdr_view),
    .total (total_nxt),
    .res   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (!blocked) begin
        in_valid_r <= in_valid;
      end
      count_r <= count_nxt;
      if (fire_last) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!blocked) begin
      byte_r <= in_data_byte;
      last_r <= in_last_byte;
    end
    if (fire && count_r < CNT_W'(HDR_KEEP)) begin
      hdr_r[count_r[HDR_IDX_W-1:0]] <= byte_r;
    end
    if (fire_last) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = res_r.status;
  assign out_msg_type       = res_r.msg_type;
  assign out_msg_code       = res_r.msg_code;
  assign out_checksum       = res_r.checksum;
  assign out_ident          = res_r.ident;
  assign out_seq_number     = res_r.seq_number;
  assign out_rest_word      = res_r.rest_word;
  assign out_orig_ts        = res_r.orig_ts;
  assign out_recv_ts        = res_r.recv_ts;
  assign out_xmit_ts        = res_r.xmit_ts;
  assign out_payload_length = res_r.payload_length;
  assign out_total_length   = res_r.total_length;

  assign err_out     = out_valid && out_status != STATUS_OK;
  assign err_nonzero = out_msg_type != 8'd0 || out_total_length != 16'd0 ||
                       out_rest_word != 32'd0;
  assign ts_out      = out_valid && out_status == STATUS_OK &&
                       out_msg_type inside {TYPE_TS_REQUEST, TYPE_TS_REPLY};
  assign ts_len_ok   = out_total_length == TS_MSG_BYTES && out_payload_length == 16'd0;

  `ICMP4_ASSERT_SAME(a_err_fields_zero, err_out, !err_nonzero, "error result with fields set")
  `ICMP4_ASSERT_SAME(a_ts_exact_len, ts_out, ts_len_ok, "timestamp result with wrong lengths")
  `ICMP4_ASSERT_NEXT(a_count_clears, fire_last, count_r == '0, "byte count not cleared")
  `ICMP4_ASSERT_SAME(a_stall_cause, in_stall, out_valid_r && out_stall, "stall without cause")

endmodule

// ===== test/icmp4_header_parser_tb.sv =====
module icmp4_header_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import icmp4_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_BYTES = 65;
  localparam int PHASE_MSGS  = 3;

  typedef enum logic [1:0] {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  typedef struct {
    logic [7:0] kind;
    int         len;
    fill_t      fill;
    bit         pinned;
    logic [1:0] want_status;
  } msg_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [7:0]  out_msg_type;
  logic [7:0]  out_msg_code;
  logic [15:0] out_checksum;
  logic [15:0] out_ident;
  logic [15:0] out_seq_number;
  logic [31:0] out_rest_word;
  logic [31:0] out_orig_ts;
  logic [31:0] out_recv_ts;
  logic [31:0] out_xmit_ts;
  logic [15:0] out_payload_length;
  logic [15:0] out_total_length;

  // hand-written expectation travelling with the byte that closes a message
  bit      drv_pinned = 1'b0;
  result_t drv_pinned_res = '0;

  int idle_pct = 0;
  int stall_pct = 0;

  // predictor state
  logic [7:0]  seen_hdr [HDR_KEEP];
  logic [15:0] seen_count = '0;
  result_t     pending_results [$];

  int mismatches = 0;
  int cycle_count = 0;
  int bytes_sent = 0;
  int msgs_sent = 0;
  int results_checked = 0;
  int status_seen [4] = '{0, 0, 0, 0};

  msg_row_t directed_rows [19] = '{
    '{TYPE_ECHO_REPLY,    8,     FILL_ZERO,   1'b0, STATUS_OK},
    '{TYPE_ECHO_REQUEST,  8,     FILL_ONES,   1'b0, STATUS_OK},
    '{TYPE_DEST_UNREACH,  12,    FILL_RANDOM, 1'b0, STATUS_OK},
    '{TYPE_SRC_QUENCH,    8,     FILL_RANDOM, 1'b0, STATUS_OK},
    '{TYPE_REDIRECT,      9,     FILL_RANDOM, 1'b0, STATUS_OK},
    '{TYPE_TIME_EXCEEDED, 30,    FILL_RANDOM, 1'b0, STATUS_OK},
    '{TYPE_PARAM_PROBLEM, 8,     FILL_ONES,   1'b0, STATUS_OK},
    '{TYPE_TS_REQUEST,    20,    FILL_RANDOM, 1'b0, STATUS_OK},
    '{TYPE_TS_REPLY,      20,    FILL_ONES,   1'b0, STATUS_OK},
    '{TYPE_INFO_REQUEST,  8,     FILL_RANDOM, 1'b0, STATUS_OK},
    '{TYPE_INFO_REPLY,    10,    FILL_RANDOM, 1'b0, STATUS_OK},
    '{TYPE_ECHO_REQUEST,  1,     FILL_ONES,   1'b1, STATUS_MISSING},
    '{TYPE_ECHO_REPLY,    3,     FILL_ONES,   1'b1, STATUS_MISSING},
    '{8'hFF,              4,     FILL_ONES,   1'b1, STATUS_UNKNOWN},
    '{8'd2,               40,    FILL_ZERO,   1'b1, STATUS_UNKNOWN},
    '{TYPE_REDIRECT,      7,     FILL_RANDOM, 1'b1, STATUS_MISSING},
    '{TYPE_TS_REQUEST,    19,    FILL_RANDOM, 1'b1, STATUS_MISSING},
    '{TYPE_TS_REPLY,      21,    FILL_RANDOM, 1'b1, STATUS_TS_LONG},
    '{TYPE_ECHO_REPLY,    4,     FILL_RANDOM, 1'b1, STATUS_MISSING}
  };

  icmp4_header_parser i_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("** icmp4_header_parser: FAILED **");
      $finish;
    end
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  function automatic logic [15:0] hdr_be16(int pos);
    return {seen_hdr[pos], seen_hdr[pos+1]};
  endfunction

  function automatic logic [31:0] hdr_be32(int pos);
    return {hdr_be16(pos), hdr_be16(pos + 2)};
  endfunction

  function automatic result_t decode_header(logic [15:0] total);
    result_t r;
    r = '0;
    if (total < MIN_BASE_BYTES) begin
      r.status = STATUS_MISSING;
      return r;
    end
    case (seen_hdr[0])
      TYPE_ECHO_REPLY, TYPE_ECHO_REQUEST, TYPE_INFO_REQUEST, TYPE_INFO_REPLY: begin
        if (total < MIN_HDR_BYTES) begin
          r.status = STATUS_MISSING;
          return r;
        end
        r.ident = hdr_be16(4);
        r.seq_number = hdr_be16(6);
        r.payload_length = total - MIN_HDR_BYTES;
      end
      TYPE_DEST_UNREACH, TYPE_SRC_QUENCH, TYPE_REDIRECT, TYPE_TIME_EXCEEDED,
      TYPE_PARAM_PROBLEM: begin
        if (total < MIN_HDR_BYTES) begin
          r.status = STATUS_MISSING;
          return r;
        end
        r.rest_word = hdr_be32(4);
        r.payload_length = total - MIN_HDR_BYTES;
      end
      TYPE_TS_REQUEST, TYPE_TS_REPLY: begin
        if (total != TS_MSG_BYTES) begin
          r.status = (total < TS_MSG_BYTES) ? STATUS_MISSING : STATUS_TS_LONG;
          return r;
        end
        r.ident = hdr_be16(4);
        r.seq_number = hdr_be16(6);
        r.orig_ts = hdr_be32(8);
        r.recv_ts = hdr_be32(12);
        r.xmit_ts = hdr_be32(16);
      end
      default: begin
        r.status = STATUS_UNKNOWN;
        return r;
      end
    endcase
    r.status = STATUS_OK;
    r.msg_type = seen_hdr[0];
    r.msg_code = seen_hdr[1];
    r.checksum = hdr_be16(2);
    r.total_length = total;
    return r;
  endfunction

  task automatic note_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      note_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
  endtask

  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{out_status, out_msg_type, out_msg_code, out_checksum, out_ident,
                out_seq_number, out_rest_word, out_orig_ts, out_recv_ts, out_xmit_ts,
                out_payload_length, out_total_length};
        if (pending_results.size() == 0) begin
          note_mismatch("result transfer with nothing expected");
        end else begin
          want = pending_results.pop_front();
          check_field("status", 32'(got.status), 32'(want.status));
          check_field("msg_type", 32'(got.msg_type), 32'(want.msg_type));
          check_field("msg_code", 32'(got.msg_code), 32'(want.msg_code));
          check_field("checksum", 32'(got.checksum), 32'(want.checksum));
          check_field("ident", 32'(got.ident), 32'(want.ident));
          check_field("seq_number", 32'(got.seq_number), 32'(want.seq_number));
          check_field("rest_word", got.rest_word, want.rest_word);
          check_field("orig_ts", got.orig_ts, want.orig_ts);
          check_field("recv_ts", got.recv_ts, want.recv_ts);
          check_field("xmit_ts", got.xmit_ts, want.xmit_ts);
          check_field("payload_length", 32'(got.payload_length),
                      32'(want.payload_length));
          check_field("total_length", 32'(got.total_length), 32'(want.total_length));
          results_checked++;
          status_seen[want.status]++;
        end
      end
      if (in_valid && !in_stall) begin
        if (seen_count < HDR_KEEP) seen_hdr[seen_count] = in_data_byte;
        if (seen_count != MAX_MESSAGE_BYTES) seen_count++;
        if (in_last_byte) begin
          pending_results.push_back(drv_pinned ? drv_pinned_res : decode_header(seen_count));
          seen_count = '0;
        end
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic last, bit pin, result_t pres);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    drv_pinned <= pin;
    drv_pinned_res <= pres;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_message(logic [7:0] kind, int len, fill_t fill, bit pin, result_t pres);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hFF;
        default:   b = 8'($urandom_range(255));
      endcase
      if (i == 0) b = kind;
      send_byte(b, i == len - 1, pin, pres);
    end
    msgs_sent++;
  endtask

  // mostly well-formed messages of handled types, some short, long or unknown
  task automatic random_message();
    logic [7:0] kind;
    int len;
    int pick;
    pick = $urandom_range(99);
    if (pick < 78) begin
      case ($urandom_range(12))
        0:       kind = TYPE_ECHO_REPLY;
        1:       kind = TYPE_DEST_UNREACH;
        2:       kind = TYPE_SRC_QUENCH;
        3:       kind = TYPE_REDIRECT;
        4:       kind = TYPE_ECHO_REQUEST;
        5:       kind = TYPE_TIME_EXCEEDED;
        6:       kind = TYPE_PARAM_PROBLEM;
        7, 11:   kind = TYPE_TS_REQUEST;
        8, 12:   kind = TYPE_TS_REPLY;
        9:       kind = TYPE_INFO_REQUEST;
        default: kind = TYPE_INFO_REPLY;
      endcase
    end else begin
      kind = 8'($urandom_range(255));
    end
    if (kind == TYPE_TS_REQUEST || kind == TYPE_TS_REPLY) begin
      pick = $urandom_range(9);
      if (pick < 7) len = 20;
      else if (pick == 7) len = $urandom_range(19, 1);
      else len = $urandom_range(40, 21);
    end else if ($urandom_range(9) < 8) begin
      len = $urandom_range(28, 8);
    end else begin
      len = $urandom_range(7, 1);
    end
    send_message(kind, len, FILL_RANDOM, 1'b0, '0);
  endtask

  // sender holds off until every outstanding result has been seen
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    result_t err;
    int start_bytes;
    int start_msgs;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      err = '0;
      err.status = directed_rows[i].want_status;
      send_message(directed_rows[i].kind, directed_rows[i].len, directed_rows[i].fill,
                   directed_rows[i].pinned, err);
    end
    wait_for_results();

    for (int ph = 0; ph < 4; ph++) begin
      @(posedge clk);
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 72; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 72; end
        default: begin idle_pct = 21; stall_pct = 21; end
      endcase
      start_bytes = bytes_sent;
      start_msgs = msgs_sent;
      while (bytes_sent - start_bytes < PHASE_BYTES || msgs_sent - start_msgs < PHASE_MSGS)
        random_message();
      wait_for_results();
    end

    repeat (8) @(negedge clk);
    if (pending_results.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    $display("%0d bytes in %0d messages, %0d results checked, %0d mismatches",
             bytes_sent, msgs_sent, results_checked, mismatches);
    $display("status mix: ok %0d, missing %0d, long timestamp %0d, unknown type %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (mismatches == 0)
      $display("** icmp4_header_parser: PASSED **");
    else
      $display("** icmp4_header_parser: FAILED **");
    $finish;
  end

endmodule
